>>> rtl/core/hdlcu_pkg.sv
// shared constants and types for the hdlc byte unstuffing receiver
// no dependencies
package hdlcu_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 4096;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned POS_W           = 12;
  localparam int unsigned COUNT_W         = 13;
  localparam int unsigned EVENT_W         = 2;
  localparam int unsigned OUT_DATA_W      = 40;

  localparam logic [BYTE_W-1:0]  FLAG_BYTE   = 8'h7e;
  localparam logic [BYTE_W-1:0]  ESC_BYTE    = 8'h7d;
  localparam logic [BYTE_W-1:0]  ESC_XOR     = 8'h20;
  localparam logic [COUNT_W-1:0] LIMIT_CAP   = COUNT_W'(MAX_FRAME_BYTES);
  localparam logic [COUNT_W-1:0] MAX_LEN_RST = COUNT_W'(4096);

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 2'd0,
    EV_DATA     = 2'd1,
    EV_DONE     = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    event_t             event_res;
    logic [BYTE_W-1:0]  data_byte;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] frame_length;
  } result_t;

endpackage

>>> rtl/core/hdlc_byte_unstuff_receiver.sv
// hdlc byte unstuffing receiver, top level
// each raw byte gives one result word, through the input register and then the result register
// throughput: one raw byte per cycle unless m_tready stalls, set by the state update loop
// rst (synchronous, active high) clears mode to unsynced, count to 0, max_length to 4096
// depends on hdlcu_pkg, hdlcu_in_reg, hdlcu_deframer
module hdlc_byte_unstuff_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,    // max_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [hdlcu_pkg::OUT_DATA_W-1:0] m_tdata,  // data_byte, position, frame_length, zero pad
  output logic [1:0]  m_tuser       // event_res
);
  import hdlcu_pkg::*;

  in_word_t word;
  logic     take;
  result_t  result;

  hdlcu_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .word     (word)
  );

  hdlcu_deframer u_deframer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .word      (word),
    .take      (take),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .result    (result)
  );

  assign m_tdata = {7'b0, result.frame_length, result.position, result.data_byte};
  assign m_tuser = result.event_res;

endmodule

>>> rtl/core/hdlcu_in_reg.sv
// input register stage holding one received raw byte
// depends on hdlcu_pkg
module hdlcu_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              take,
  output hdlcu_pkg::in_word_t word
);
  import hdlcu_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] rx_byte;

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      rx_byte <= s_tdata;
    end
  end

  assign word.valid   = valid;
  assign word.rx_byte = rx_byte;

endmodule

>>> rtl/core/hdlcu_deframer.sv
// framing state machine, unstuffing, length limit and result register
// depends on hdlcu_pkg
module hdlcu_deframer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [12:0]            cfg_wdata,
  input  hdlcu_pkg::in_word_t    word,
  output logic                   take,
  output logic                   m_valid,
  input  logic                   m_ready,
  output hdlcu_pkg::result_t     result
);
  import hdlcu_pkg::*;

  typedef enum logic [2:0] {
    M_UNSYNCED = 3'd0,
    M_SYNCED   = 3'd1,
    M_INFRAME  = 3'd2,
    M_ESCAPE   = 3'd3,
    M_DISCARD  = 3'd4
  } mode_t;

  mode_t              mode, mode_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [COUNT_W-1:0] max_length;
  logic [COUNT_W-1:0] limit;
  logic [BYTE_W-1:0]  sbyte;
  logic               do_store;
  result_t            res_next;

  assign take  = word.valid && (!m_valid || m_ready);
  assign limit = (max_length > LIMIT_CAP) ? LIMIT_CAP : max_length;
  assign sbyte = (mode == M_ESCAPE) ? (word.rx_byte ^ ESC_XOR) : word.rx_byte;

  always_comb begin
    mode_next       = mode;
    byte_count_next = byte_count;
    do_store        = 1'b0;
    res_next        = '{EV_NONE, '0, '0, '0};
    unique case (mode)
      M_UNSYNCED: begin
        if (word.rx_byte == FLAG_BYTE) begin
          byte_count_next = '0;
          mode_next       = M_SYNCED;
        end
      end
      M_SYNCED: begin
        if (word.rx_byte == ESC_BYTE) begin
          mode_next = M_ESCAPE;
        end else if (word.rx_byte != FLAG_BYTE) begin
          do_store = 1'b1;
        end
      end
      M_INFRAME: begin
        if (word.rx_byte == FLAG_BYTE) begin
          res_next.event_res    = EV_DONE;
          res_next.frame_length = byte_count;
          byte_count_next       = '0;
          mode_next             = M_UNSYNCED;
        end else if (word.rx_byte == ESC_BYTE) begin
          mode_next = M_ESCAPE;
        end else begin
          do_store = 1'b1;
        end
      end
      M_ESCAPE: begin
        do_store = 1'b1;
      end
      M_DISCARD: begin
        if (word.rx_byte == FLAG_BYTE) begin
          byte_count_next = '0;
          mode_next       = M_UNSYNCED;
        end
      end
      default: begin
        mode_next = M_UNSYNCED;
      end
    endcase
    if (do_store) begin
      if (byte_count >= limit) begin
        res_next.event_res = EV_OVERFLOW;
        mode_next          = M_DISCARD;
      end else begin
        res_next.event_res = EV_DATA;
        res_next.data_byte = sbyte;
        res_next.position  = byte_count[POS_W-1:0];
        byte_count_next    = byte_count + COUNT_W'(1);
        mode_next          = M_INFRAME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_UNSYNCED;
      byte_count <= '0;
      max_length <= MAX_LEN_RST;
      m_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_wdata;
      end
      if (take) begin
        mode       <= mode_next;
        byte_count <= byte_count_next;
        m_valid    <= 1'b1;
      end else if (m_ready) begin
        m_valid    <= 1'b0;
      end
    end
    if (take) begin
      result <= res_next;
    end
  end

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LIMIT_CAP)
    else $error("frame byte count above cap");

  a_unsynced_exit: assert property (@(posedge clk) disable iff (rst)
    (take && mode == M_UNSYNCED) |=> (mode == M_UNSYNCED || mode == M_SYNCED))
    else $error("left unsynced without a flag");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (take && res_next.event_res == EV_DONE) |=> (byte_count == '0 && mode == M_UNSYNCED))
    else $error("closing flag did not clear the frame");

  a_data_counts: assert property (@(posedge clk) disable iff (rst)
    (take && res_next.event_res == EV_DATA)
      |=> (byte_count == $past(byte_count) + COUNT_W'(1) && mode == M_INFRAME))
    else $error("stored byte did not advance the count");

  a_overflow_discard: assert property (@(posedge clk) disable iff (rst)
    (take && res_next.event_res == EV_OVERFLOW) |=> (mode == M_DISCARD))
    else $error("overflow did not enter discard");

endmodule
